@@ rtl/core/prtb_pkg.sv @@
// Package for the prescaled reload timer bank.
// Holds timer count, control bit positions, prescaler shifts and access codes.
// No dependencies.
`timescale 1ns / 1ps

package prtb_pkg;

  localparam int TIMERS = 4;
  localparam int FLAG_W = 4;
  localparam int DATA_W = 16;
  localparam int ACC_W = 17;

  localparam int CTL_ENABLE_BIT = 7;
  localparam int CTL_IRQ_BIT = 6;

  // divide by 1, 64, 256, 1024
  localparam logic [3:0] PRESCALE_SHIFT [4] = '{4'd0, 4'd6, 4'd8, 4'd10};

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_CTRL  = 2'd1,
    KIND_FLAGS = 2'd2
  } reg_kind_t;

endpackage

@@ rtl/core/prescaled_reload_timer_bank.sv @@
// Top level of the prescaled reload timer bank: four 16-bit reload timers.
// Uses prtb_pkg for constants and access codes.
//
// channel | handshake               | payload
// --------+-------------------------+-----------------------------------------------
// in      | in_valid / in_ready     | opcode, timer_index, register_kind,
//         |                         | write_value, elapsed_cycles
// out     | out_valid / out_ready   | read_data, pending_flags, overflow_now
//
// One transaction per cycle while in_ready is high; the timer advance and register
// access are done in the accept cycle, and the result is registered for the output.
// A one-entry skid register holds a second result while the output is stalled;
// in_ready drops only when both are full.
// rst (synchronous) clears all timer state and empties the output side.
`timescale 1ns / 1ps

module prescaled_reload_timer_bank (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [1:0]  timer_index,
  input  logic [1:0]  register_kind,
  input  logic [15:0] write_value,
  input  logic [15:0] elapsed_cycles,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] read_data,
  output logic [3:0]  pending_flags,
  output logic [3:0]  overflow_now
);

  logic [prtb_pkg::DATA_W-1:0] count_value [prtb_pkg::TIMERS];
  logic [prtb_pkg::DATA_W-1:0] reload_value [prtb_pkg::TIMERS];
  logic [prtb_pkg::DATA_W-1:0] control_word [prtb_pkg::TIMERS];
  logic [prtb_pkg::ACC_W-1:0]  prescale_acc [prtb_pkg::TIMERS];
  logic [prtb_pkg::FLAG_W-1:0] interrupt_pending;

  logic [prtb_pkg::DATA_W-1:0] count_next [prtb_pkg::TIMERS];
  logic [prtb_pkg::DATA_W-1:0] reload_next [prtb_pkg::TIMERS];
  logic [prtb_pkg::DATA_W-1:0] control_next [prtb_pkg::TIMERS];
  logic [prtb_pkg::ACC_W-1:0]  prescale_acc_next [prtb_pkg::TIMERS];
  logic [prtb_pkg::FLAG_W-1:0] interrupt_pending_next;

  logic [prtb_pkg::ACC_W-1:0]  acc_sum [prtb_pkg::TIMERS];
  logic [prtb_pkg::ACC_W-1:0]  steps [prtb_pkg::TIMERS];
  logic [prtb_pkg::ACC_W:0]    cnt_sum [prtb_pkg::TIMERS];
  logic [prtb_pkg::DATA_W-1:0] count_adv [prtb_pkg::TIMERS];
  logic [prtb_pkg::ACC_W-1:0]  acc_adv [prtb_pkg::TIMERS];
  logic [prtb_pkg::FLAG_W-1:0] pend_adv;
  logic [prtb_pkg::FLAG_W-1:0] ovf;
  logic [prtb_pkg::DATA_W-1:0] rdata;

  logic [15:0] skid_read_data;
  logic [3:0]  skid_pending;
  logic [3:0]  skid_overflow;
  logic        skid_valid;

  logic in_fire;
  logic out_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // time advance
  always_comb begin
    ovf      = '0;
    pend_adv = interrupt_pending;
    for (int i = 0; i < prtb_pkg::TIMERS; i++) begin
      acc_sum[i] = prescale_acc[i] + prtb_pkg::ACC_W'(elapsed_cycles);
      steps[i] = acc_sum[i] >> prtb_pkg::PRESCALE_SHIFT[control_word[i][1:0]];
      cnt_sum[i] = (prtb_pkg::ACC_W+1)'(count_value[i]) + (prtb_pkg::ACC_W+1)'(steps[i]);
      count_adv[i] = count_value[i];
      acc_adv[i] = prescale_acc[i];
      if (control_word[i][prtb_pkg::CTL_ENABLE_BIT]) begin
        acc_adv[i] = acc_sum[i];
        if (steps[i] != '0) begin
          acc_adv[i] = '0;
          if (cnt_sum[i][prtb_pkg::ACC_W:prtb_pkg::DATA_W] != '0) begin
            count_adv[i] = reload_value[i] + cnt_sum[i][prtb_pkg::DATA_W-1:0];
            if (i < prtb_pkg::FLAG_W) begin
              ovf[i] = 1'b1;
              if (control_word[i][prtb_pkg::CTL_IRQ_BIT]) begin
                pend_adv[i] = 1'b1;
              end
            end
          end else begin
            count_adv[i] = cnt_sum[i][prtb_pkg::DATA_W-1:0];
          end
        end
      end
    end
  end

  // register access
  always_comb begin
    rdata = '0;
    interrupt_pending_next = pend_adv;
    for (int i = 0; i < prtb_pkg::TIMERS; i++) begin
      count_next[i] = count_adv[i];
      reload_next[i] = reload_value[i];
      control_next[i] = control_word[i];
      prescale_acc_next[i] = acc_adv[i];
    end
    case (opcode)
      prtb_pkg::OP_READ: begin
        case (register_kind)
          prtb_pkg::KIND_FLAGS: rdata = prtb_pkg::DATA_W'(pend_adv);
          prtb_pkg::KIND_COUNT: begin
            for (int i = 0; i < prtb_pkg::TIMERS; i++) begin
              if (int'(timer_index) == i) begin
                rdata = count_adv[i];
              end
            end
          end
          prtb_pkg::KIND_CTRL: begin
            for (int i = 0; i < prtb_pkg::TIMERS; i++) begin
              if (int'(timer_index) == i) begin
                rdata = control_word[i];
              end
            end
          end
          default: rdata = '0;
        endcase
      end
      prtb_pkg::OP_WRITE: begin
        case (register_kind)
          prtb_pkg::KIND_FLAGS: begin
            interrupt_pending_next = pend_adv & ~write_value[prtb_pkg::FLAG_W-1:0];
          end
          prtb_pkg::KIND_COUNT: begin
            for (int i = 0; i < prtb_pkg::TIMERS; i++) begin
              if (int'(timer_index) == i) begin
                reload_next[i] = write_value;
                count_next[i] = write_value;
              end
            end
          end
          prtb_pkg::KIND_CTRL: begin
            for (int i = 0; i < prtb_pkg::TIMERS; i++) begin
              if (int'(timer_index) == i) begin
                control_next[i] = write_value;
                if (write_value[prtb_pkg::CTL_ENABLE_BIT]) begin
                  count_next[i] = reload_value[i];
                  prescale_acc_next[i] = '0;
                end
              end
            end
          end
          default: rdata = '0;
        endcase
      end
      default: rdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < prtb_pkg::TIMERS; i++) begin
        count_value[i] <= '0;
        reload_value[i] <= '0;
        control_word[i] <= '0;
        prescale_acc[i] <= '0;
      end
      interrupt_pending <= '0;
    end else if (in_fire) begin
      for (int i = 0; i < prtb_pkg::TIMERS; i++) begin
        count_value[i] <= count_next[i];
        reload_value[i] <= reload_next[i];
        control_word[i] <= control_next[i];
        prescale_acc[i] <= prescale_acc_next[i];
      end
      interrupt_pending <= interrupt_pending_next;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        read_data     <= skid_read_data;
        pending_flags <= skid_pending;
        overflow_now  <= skid_overflow;
      end else begin
        read_data     <= rdata;
        pending_flags <= interrupt_pending_next;
        overflow_now  <= ovf;
      end
    end else if (in_fire) begin
      skid_read_data <= rdata;
      skid_pending   <= interrupt_pending_next;
      skid_overflow  <= ovf;
    end
  end

endmodule

@@ rtl/core/prtb_checker.sv @@
// Port-level checker for the prescaled reload timer bank, with its bind.
// Uses prtb_pkg for access codes; attaches to prescaled_reload_timer_bank.
`timescale 1ns / 1ps

module prtb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  opcode,
  input logic [1:0]  timer_index,
  input logic [1:0]  register_kind,
  input logic [15:0] write_value,
  input logic [15:0] elapsed_cycles,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] read_data,
  input logic [3:0]  pending_flags,
  input logic [3:0]  overflow_now
);

  // output side comes up empty after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("out_valid high right after reset");

  // backpressure only when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with no result held");

  a_empty_is_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("empty block not ready");

  // a non-read transaction into an empty block reads zero in the next cycle
  a_tick_reads_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid && opcode != prtb_pkg::OP_READ
    |=> out_valid && read_data == 16'd0)
    else $error("non-read transaction returned data");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data)
      && $stable(pending_flags) && $stable(overflow_now))
    else $error("stalled result changed");

endmodule

bind prescaled_reload_timer_bank prtb_checker u_prtb_checker (.*);

@@ dv/tb.sv @@
// Self-checking testbench for prescaled_reload_timer_bank: directed register, overflow and
// prescaler tests, then random bursty traffic under output back-pressure.
// Depends on prtb_pkg and the prescaled_reload_timer_bank RTL.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_TICK_ALT = 2'd3;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] PS_DIV1 = 2'd0;
  localparam logic [1:0] PS_DIV64 = 2'd1;
  localparam logic [1:0] PS_DIV256 = 2'd2;
  localparam logic [1:0] PS_DIV1024 = 2'd3;
  localparam int unsigned PRESCALE_DIV [4] = '{1, 64, 256, 1024};
  localparam int HOLDOFF_CYCLES = 60;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  pending_flags;
    logic [3:0]  overflow_now;
  } timer_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [1:0]  timer_index;
  logic [1:0]  register_kind;
  logic [15:0] write_value;
  logic [15:0] elapsed_cycles;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] read_data;
  logic [3:0]  pending_flags;
  logic [3:0]  overflow_now;

  // timer bank shadow state
  logic [15:0] shadow_count [prtb_pkg::TIMERS];
  logic [15:0] timer_reload [prtb_pkg::TIMERS];
  logic [15:0] timer_ctrl [prtb_pkg::TIMERS];
  logic [prtb_pkg::ACC_W-1:0] prescale_acc [prtb_pkg::TIMERS];
  logic [prtb_pkg::FLAG_W-1:0] irq_pending;

  timer_result_t result_q [$];
  int fail_count;
  int sent_count;
  int checked_count;
  int overflow_seen;
  int cycle_count;
  int burst_left;
  bit pace_gaps;
  bit holdoff_req;
  int unsigned rx_tick;

  prescaled_reload_timer_bank DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .timer_index(timer_index),
    .register_kind(register_kind),
    .write_value(write_value),
    .elapsed_cycles(elapsed_cycles),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .pending_flags(pending_flags),
    .overflow_now(overflow_now)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] ctrl_word(bit en, bit irq, logic [1:0] sel);
    logic [15:0] w;
    w = '0;
    w[prtb_pkg::CTL_ENABLE_BIT] = en;
    w[prtb_pkg::CTL_IRQ_BIT] = irq;
    w[1:0] = sel;
    return w;
  endfunction

  function automatic timer_result_t advance_and_access(logic [1:0] op, logic [1:0] idx,
                                                       logic [1:0] kind, logic [15:0] wdata,
                                                       logic [15:0] cycles);
    timer_result_t r;
    int unsigned steps;
    int unsigned total;
    r = '0;
    for (int t = 0; t < prtb_pkg::TIMERS; t++) begin
      if (timer_ctrl[t][prtb_pkg::CTL_ENABLE_BIT]) begin
        prescale_acc[t] = prescale_acc[t] + cycles;
        steps = prescale_acc[t] / PRESCALE_DIV[timer_ctrl[t][1:0]];
        if (steps != 0) begin
          prescale_acc[t] = '0;
          total = shadow_count[t] + steps;
          if (total >= 32'h10000) begin
            shadow_count[t] = timer_reload[t] + total[15:0];
            r.overflow_now[t] = 1'b1;
            if (timer_ctrl[t][prtb_pkg::CTL_IRQ_BIT]) irq_pending[t] = 1'b1;
          end else begin
            shadow_count[t] = total[15:0];
          end
        end
      end
    end
    if (op == prtb_pkg::OP_READ) begin
      case (kind)
        prtb_pkg::KIND_FLAGS: r.read_data = {12'h000, irq_pending};
        prtb_pkg::KIND_COUNT: r.read_data = shadow_count[idx];
        prtb_pkg::KIND_CTRL: r.read_data = timer_ctrl[idx];
        default: r.read_data = '0;
      endcase
    end else if (op == prtb_pkg::OP_WRITE) begin
      case (kind)
        prtb_pkg::KIND_FLAGS: irq_pending = irq_pending & ~wdata[prtb_pkg::FLAG_W-1:0];
        prtb_pkg::KIND_COUNT: begin
          timer_reload[idx] = wdata;
          shadow_count[idx] = wdata;
        end
        prtb_pkg::KIND_CTRL: begin
          timer_ctrl[idx] = wdata;
          if (wdata[prtb_pkg::CTL_ENABLE_BIT]) begin
            shadow_count[idx] = timer_reload[idx];
            prescale_acc[idx] = '0;
          end
        end
        default: ;
      endcase
    end
    r.pending_flags = irq_pending;
    return r;
  endfunction

  // predict on accept, check on result
  always @(posedge clk) begin
    timer_result_t exp_r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        result_q.push_back(advance_and_access(opcode, timer_index, register_kind,
                                              write_value, elapsed_cycles));
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result transaction: read_data %h", read_data);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          checked_count++;
          if (overflow_now != 0) overflow_seen++;
          if (read_data !== exp_r.read_data) begin
            $error("read_data: expected %h, got %h", exp_r.read_data, read_data);
            fail_count++;
          end
          if (pending_flags !== exp_r.pending_flags) begin
            $error("pending_flags: expected %h, got %h", exp_r.pending_flags, pending_flags);
            fail_count++;
          end
          if (overflow_now !== exp_r.overflow_now) begin
            $error("overflow_now: expected %h, got %h", exp_r.overflow_now, overflow_now);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               result_q.size());
      $display("prescaled_reload_timer_bank regression: fail");
      $finish;
    end
  end

  // receiver: own stall pattern plus requested long hold-off
  initial begin
    out_ready = 1'b0;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        out_ready = 1'b0;
        holdoff_req = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end else begin
        rx_tick++;
        case ((rx_tick >> 8) % 4)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ($urandom_range(0, 3) != 0);
          default: out_ready = (rx_tick % 5 != 0);
        endcase
      end
    end
  end

  task automatic send_txn(logic [1:0] op, logic [1:0] idx, logic [1:0] kind,
                          logic [15:0] wdata, logic [15:0] cycles);
    int idle;
    idle = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (pace_gaps && $urandom_range(0, 3) != 0) idle = $urandom_range(1, 8);
    end
    @(negedge clk);
    if (idle > 0) begin
      in_valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    opcode = op;
    timer_index = idx;
    register_kind = kind;
    write_value = wdata;
    elapsed_cycles = cycles;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_register_access();
    send_txn(prtb_pkg::OP_WRITE, 2'd0, prtb_pkg::KIND_COUNT, 16'hFFFF, 16'h0000);
    send_txn(prtb_pkg::OP_WRITE, 2'd3, prtb_pkg::KIND_COUNT, 16'h0000, 16'h0000);
    send_txn(prtb_pkg::OP_WRITE, 2'd1, prtb_pkg::KIND_CTRL, 16'hFF7F, 16'hFFFF);
    send_txn(prtb_pkg::OP_READ, 2'd0, prtb_pkg::KIND_COUNT, 16'h0000, 16'h0000);
    send_txn(prtb_pkg::OP_READ, 2'd3, prtb_pkg::KIND_COUNT, 16'hFFFF, 16'h0000);
    send_txn(prtb_pkg::OP_READ, 2'd1, prtb_pkg::KIND_CTRL, 16'h0000, 16'h0001);
    send_txn(prtb_pkg::OP_WRITE, 2'd2, KIND_NONE, 16'hFFFF, 16'h0000);
    send_txn(prtb_pkg::OP_READ, 2'd2, KIND_NONE, 16'h0000, 16'h0000);
    send_txn(OP_TICK_ALT, 2'd3, prtb_pkg::KIND_COUNT, 16'hFFFF, 16'h0000);
    send_txn(prtb_pkg::OP_READ, 2'd3, prtb_pkg::KIND_FLAGS, 16'h0000, 16'h0000);
  endtask

  task automatic test_overflow_reload();
    send_txn(prtb_pkg::OP_WRITE, 2'd0, prtb_pkg::KIND_COUNT, 16'hFFF0, 16'h0000);
    send_txn(prtb_pkg::OP_WRITE, 2'd0, prtb_pkg::KIND_CTRL, ctrl_word(1'b1, 1'b1, PS_DIV1),
             16'h0000);
    send_txn(prtb_pkg::OP_TICK, 2'd0, prtb_pkg::KIND_COUNT, 16'h0000, 16'h0010);
    send_txn(prtb_pkg::OP_READ, 2'd0, prtb_pkg::KIND_COUNT, 16'h0000, 16'h0000);
    send_txn(prtb_pkg::OP_TICK, 2'd0, prtb_pkg::KIND_COUNT, 16'h0000, 16'hFFFF);
    send_txn(prtb_pkg::OP_WRITE, 2'd2, prtb_pkg::KIND_CTRL, ctrl_word(1'b0, 1'b1, PS_DIV1),
             16'hFFFF);
    send_txn(prtb_pkg::OP_WRITE, 2'd1, prtb_pkg::KIND_FLAGS, 16'hFFFE, 16'h0000);
    send_txn(prtb_pkg::OP_WRITE, 2'd1, prtb_pkg::KIND_FLAGS, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_prescalers();
    send_txn(prtb_pkg::OP_WRITE, 2'd1, prtb_pkg::KIND_CTRL, ctrl_word(1'b1, 1'b0, PS_DIV64),
             16'h0000);
    send_txn(prtb_pkg::OP_TICK, 2'd1, prtb_pkg::KIND_COUNT, 16'h0000, 16'd63);
    send_txn(prtb_pkg::OP_READ, 2'd1, prtb_pkg::KIND_COUNT, 16'h0000, 16'd1);
    send_txn(prtb_pkg::OP_WRITE, 2'd2, prtb_pkg::KIND_CTRL, ctrl_word(1'b1, 1'b1, PS_DIV256),
             16'd300);
    send_txn(prtb_pkg::OP_WRITE, 2'd2, prtb_pkg::KIND_COUNT, 16'hFFFF, 16'd200);
    send_txn(prtb_pkg::OP_READ, 2'd2, prtb_pkg::KIND_COUNT, 16'h0000, 16'd100);
    send_txn(prtb_pkg::OP_WRITE, 2'd3, prtb_pkg::KIND_CTRL,
             ctrl_word(1'b1, 1'b1, PS_DIV1024), 16'hFFFF);
    send_txn(prtb_pkg::OP_WRITE, 2'd1, prtb_pkg::KIND_CTRL, ctrl_word(1'b0, 1'b0, PS_DIV64),
             16'd128);
    send_txn(prtb_pkg::OP_READ, 2'd3, prtb_pkg::KIND_CTRL, 16'h0000, 16'hFFFF);
  endtask

  task automatic send_random_txn();
    logic [1:0] op;
    logic [1:0] idx;
    logic [1:0] kind;
    logic [15:0] wdata;
    logic [15:0] cycles;
    int sel;
    idx = 2'($urandom);
    kind = 2'($urandom_range(prtb_pkg::KIND_FLAGS));
    wdata = 16'($urandom);
    case ($urandom_range(0, 9))
      0: cycles = '0;
      1: cycles = 16'hFFFF;
      2, 3, 4, 5: cycles = 16'($urandom_range(0, 300));
      6, 7: cycles = 16'($urandom_range(0, 4096));
      default: cycles = 16'($urandom);
    endcase
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      op = ($urandom_range(0, 7) == 0) ? OP_TICK_ALT : prtb_pkg::OP_TICK;
      kind = 2'($urandom);
    end else if (sel < 60) begin
      op = prtb_pkg::OP_READ;
      if ($urandom_range(0, 9) == 0) kind = KIND_NONE;
    end else if (sel < 80) begin
      op = prtb_pkg::OP_WRITE;
      kind = prtb_pkg::KIND_COUNT;
      if ($urandom_range(0, 2) != 0) wdata[15:8] = 8'hFF;
    end else if (sel < 93) begin
      op = prtb_pkg::OP_WRITE;
      kind = prtb_pkg::KIND_CTRL;
      wdata[prtb_pkg::CTL_ENABLE_BIT] = ($urandom_range(0, 3) != 0);
    end else begin
      op = prtb_pkg::OP_WRITE;
      kind = ($urandom_range(0, 4) == 0) ? KIND_NONE : prtb_pkg::KIND_FLAGS;
    end
    send_txn(op, idx, kind, wdata, cycles);
  endtask

  task automatic test_output_holdoff();
    pace_gaps = 1'b0;
    holdoff_req = 1'b1;
    repeat (24) send_random_txn();
    pace_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (15) send_random_txn();
    wait_drained();
    repeat (15) send_random_txn();
    wait_drained();
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_random_txn();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = prtb_pkg::OP_TICK;
    timer_index = '0;
    register_kind = prtb_pkg::KIND_COUNT;
    write_value = '0;
    elapsed_cycles = '0;
    fail_count = 0;
    sent_count = 0;
    checked_count = 0;
    overflow_seen = 0;
    cycle_count = 0;
    burst_left = 0;
    pace_gaps = 1'b1;
    holdoff_req = 1'b0;
    for (int t = 0; t < prtb_pkg::TIMERS; t++) begin
      shadow_count[t] = '0;
      timer_reload[t] = '0;
      timer_ctrl[t] = '0;
      prescale_acc[t] = '0;
    end
    irq_pending = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_register_access();
    test_overflow_reload();
    test_prescalers();
    test_output_holdoff();
    test_drain_pause();
    test_random_traffic(870);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d transactions sent, %0d results checked, %0d with timer overflow", sent_count,
             checked_count, overflow_seen);
    $display("covered register access on all timers, every prescaler, reload overflow,");
    $display("flag clear and back-pressure");
    if (fail_count == 0 && result_q.size() == 0) begin
      $display("prescaled_reload_timer_bank regression: pass");
    end else begin
      $display("prescaled_reload_timer_bank regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/prtb_pkg.sv
rtl/core/prescaled_reload_timer_bank.sv
rtl/core/prtb_checker.sv
dv/tb.sv
